/* sv/gru_cell_fixed_weight_element_core_assert.svh */
// ----------------------------------------------------------------------------
// GRU element core assertion macros
// Shared property forms for the core's checker.
// ----------------------------------------------------------------------------
`ifndef GRU_CELL_FIXED_WEIGHT_ELEMENT_CORE_ASSERT_SVH
`define GRU_CELL_FIXED_WEIGHT_ELEMENT_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define GCFW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define GCFW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, always active
`define GCFW_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/gcfw_pkg.sv */
// ----------------------------------------------------------------------------
// GRU element core package
// Weights, sigmoid breakpoint table and fixed-point helpers.
// ----------------------------------------------------------------------------
package gcfw_pkg;

  localparam int NSTG = 9;

  // Q0.12 weights
  localparam logic signed [12:0] W_Z_P  = 13'sd2048;
  localparam logic signed [12:0] W_Z_X  = 13'sd1229;
  localparam logic signed [12:0] W_Z_A  = 13'sd819;
  localparam logic signed [12:0] W_R_P  = 13'sd1638;
  localparam logic signed [12:0] W_R_X  = 13'sd1638;
  localparam logic signed [12:0] W_R_A  = 13'sd819;
  localparam logic signed [12:0] W_C_RP = 13'sd2458;
  localparam logic signed [12:0] W_C_X  = 13'sd1638;
  localparam logic signed [13:0] ONE_Q12 = 14'sd4096;

  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  typedef logic [12:0] sig_tbl_t [0:256];

  typedef struct packed {
    logic [12:0] lo;
    logic [12:0] hi;
    logic [7:0]  f;
  } lut_t;

  // breakpoint k = round(4096 * sig(-8 + k/16)), elaboration only
  function automatic sig_tbl_t build_sig_tbl();
    sig_tbl_t    t;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    int          n;
    int          b;
    e = 64'd1 << 32;
    for (n = 0; n <= 128; n++) begin
      den = (64'd1 << 32) + e;
      num = (64'd1 << 44) + (den >> 1);
      rem = '0;
      q   = '0;
      for (b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem  = rem - den;
          q[b] = 1'b1;
        end
      end
      t[128 + n] = q[12:0];
      t[128 - n] = 13'd4096 - q[12:0];
      e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam sig_tbl_t SIG_TBL = build_sig_tbl();

  // round Q*.24 to Q*.12, nearest, ties up
  function automatic logic signed [17:0] rnd12(input logic signed [29:0] v);
    logic signed [29:0] t;
    t = v + 30'sd2048;
    return 18'(t >>> 12);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  function automatic lut_t lut_fetch(input logic signed [15:0] a);
    logic [7:0] idx;
    lut_t       l;
    idx  = {~a[15], a[14:8]};
    l.lo = SIG_TBL[9'(idx)];
    l.hi = SIG_TBL[9'(idx) + 9'd1];
    l.f  = a[7:0];
    return l;
  endfunction

  function automatic logic signed [13:0] interp(input lut_t l);
    logic signed [13:0] d;
    logic signed [22:0] pr;
    d  = $signed({1'b0, l.hi}) - $signed({1'b0, l.lo});
    pr = 23'(d) * $signed({15'd0, l.f});
    pr = pr + 23'sd128;
    return $signed({1'b0, l.lo}) + 14'(pr >>> 8);
  endfunction

endpackage

/* sv/gru_cell_fixed_weight_element_core.sv */
// ----------------------------------------------------------------------------
// GRU element core
// Element-wise GRU cell, fixed weights, shared sigmoid table lookup.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled;
// each of the 9 stages holds one item.
// Stages: gate sums, gate lookup, gate interp, r*p, candidate sum,
// tanh lookup, tanh interp, blend products, round/saturate output.
// Reset: synchronous, clears all stage valid bits; items in flight are dropped.
module gru_cell_fixed_weight_element_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // prev_state, obs_feature, upstream_mean
  input  logic        s_axis_tlast,   // last_element
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // new_state
  output logic        m_axis_tlast    // last_out
);
  import gcfw_pkg::*;

  logic [NSTG:1] vld;
  logic [NSTG:1] vld_in;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !vld[NSTG] || m_axis_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k + 1];
    end
  end

  assign vld_in        = {vld[NSTG-1:1], s_axis_tvalid};
  assign s_axis_tready = en[1];
  assign m_axis_tvalid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  logic signed [15:0] p_in, x_in, a_in;
  assign p_in = $signed(s_axis_tdata[15:0]);
  assign x_in = $signed(s_axis_tdata[31:16]);
  assign a_in = $signed(s_axis_tdata[47:32]);

  // stage 1: gate sums
  logic signed [15:0] p1, x1;
  logic               l1;
  logic signed [29:0] sz1, sr1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1  <= p_in;
      x1  <= x_in;
      l1  <= s_axis_tlast;
      sz1 <= 30'(p_in) * 30'(W_Z_P) + 30'(x_in) * 30'(W_Z_X) + 30'(a_in) * 30'(W_Z_A);
      sr1 <= 30'(p_in) * 30'(W_R_P) + 30'(x_in) * 30'(W_R_X) + 30'(a_in) * 30'(W_R_A);
    end
  end

  // stage 2: gate table reads
  logic signed [15:0] p2, x2;
  logic               l2;
  lut_t               zl2, rl2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p2  <= p1;
      x2  <= x1;
      l2  <= l1;
      zl2 <= lut_fetch(sat16(20'(rnd12(sz1))));
      rl2 <= lut_fetch(sat16(20'(rnd12(sr1))));
    end
  end

  // stage 3: gate interpolation
  logic signed [15:0] p3, x3;
  logic               l3;
  logic signed [13:0] z3, r3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p3 <= p2;
      x3 <= x2;
      l3 <= l2;
      z3 <= interp(zl2);
      r3 <= interp(rl2);
    end
  end

  // stage 4: r * p
  logic signed [15:0] p4, x4, rp4;
  logic               l4;
  logic signed [13:0] z4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      p4  <= p3;
      x4  <= x3;
      l4  <= l3;
      z4  <= z3;
      rp4 <= 16'(rnd12(30'(r3) * 30'(p3)));
    end
  end

  // stage 5: candidate sum
  logic signed [15:0] p5;
  logic               l5;
  logic signed [13:0] z5;
  logic signed [29:0] c5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p5 <= p4;
      l5 <= l4;
      z5 <= z4;
      c5 <= 30'(rp4) * 30'(W_C_RP) + 30'(x4) * 30'(W_C_X);
    end
  end

  // stage 6: tanh table read, argument doubled
  logic signed [15:0] p6;
  logic               l6;
  logic signed [13:0] z6;
  lut_t               tl6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      p6  <= p5;
      l6  <= l5;
      z6  <= z5;
      tl6 <= lut_fetch(sat16(20'(rnd12(c5)) <<< 1));
    end
  end

  // stage 7: tanh = 2*sig - 1
  logic signed [15:0] p7;
  logic               l7;
  logic signed [13:0] z7, h7;
  logic signed [14:0] hw;

  assign hw = (15'(interp(tl6)) <<< 1) - 15'(ONE_Q12);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      p7 <= p6;
      l7 <= l6;
      z7 <= z6;
      h7 <= 14'(hw);
    end
  end

  // stage 8: blend products
  logic               l8;
  logic signed [29:0] m1_8, m2_8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      l8   <= l7;
      m1_8 <= 30'(ONE_Q12 - z7) * 30'(p7);
      m2_8 <= 30'(z7) * 30'(h7);
    end
  end

  // stage 9: output register
  always_ff @(posedge clk) begin
    if (en[9]) begin
      m_axis_tlast <= l8;
      m_axis_tdata <= sat16(20'(rnd12(m1_8 + m2_8)));
    end
  end

endmodule

/* sv/gcfw_chk.sv */
// ----------------------------------------------------------------------------
// GRU element core checker
// Port-level checks on flow control and reset, bound to the core.
// ----------------------------------------------------------------------------
`include "gru_cell_fixed_weight_element_core_assert.svh"

module gcfw_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `GCFW_ASSERT_ALWAYS_NEXT(a_rst_empty, clk, rst, !m_axis_tvalid, "output valid after reset")

  `GCFW_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output item changed")

  `GCFW_ASSERT_NOW(a_ready_flow, clk, rst, m_axis_tready, s_axis_tready, "input stalled while output drains")

  `GCFW_ASSERT_NOW(a_ready_empty, clk, rst, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule

bind gru_cell_fixed_weight_element_core gcfw_chk u_gcfw_chk (.*);
